[sv/tok_pkg.sv]
// types, constants and character classes shared by the source tokenizer
package tok_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS   = 20;
	localparam int COL_BITS    = 16;
	localparam int KIND_BITS   = 6;
	localparam int SUB_BITS    = 5;
	localparam int PREFIX_BITS = 48;

	localparam int WQ_DEPTH    = 8;
	localparam int WQ_PTR_BITS = $clog2(WQ_DEPTH);
	localparam int WQ_CNT_BITS = WQ_PTR_BITS + 1;

	localparam logic [KIND_BITS-1:0] KIND_END      = 6'd0;
	localparam logic [KIND_BITS-1:0] KIND_SPACE    = 6'd1;
	localparam logic [KIND_BITS-1:0] KIND_COMMENT  = 6'd2;
	localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd3;
	localparam logic [KIND_BITS-1:0] KIND_DEF      = 6'd4;
	localparam logic [KIND_BITS-1:0] KIND_FUN      = 6'd5;
	localparam logic [KIND_BITS-1:0] KIND_RETURN   = 6'd6;
	localparam logic [KIND_BITS-1:0] KIND_INT      = 6'd7;
	localparam logic [KIND_BITS-1:0] KIND_UNKNOWN  = 6'd8;
	localparam logic [KIND_BITS-1:0] KIND_SYM_BASE = 6'd8;

	localparam logic [SUB_BITS-1:0] SUB_NONE   = 5'd0;
	localparam logic [SUB_BITS-1:0] SUB_EQ     = 5'd6;
	localparam logic [SUB_BITS-1:0] SUB_PLUS   = 5'd7;
	localparam logic [SUB_BITS-1:0] SUB_MINUS  = 5'd8;
	localparam logic [SUB_BITS-1:0] SUB_SLASH  = 5'd10;
	localparam logic [SUB_BITS-1:0] SUB_BANG   = 5'd12;
	localparam logic [SUB_BITS-1:0] SUB_GT     = 5'd13;
	localparam logic [SUB_BITS-1:0] SUB_LT     = 5'd14;
	localparam logic [SUB_BITS-1:0] SUB_ARROW  = 5'd18;
	localparam logic [SUB_BITS-1:0] SUB_INC    = 5'd19;
	localparam logic [SUB_BITS-1:0] SUB_DEC    = 5'd20;
	localparam logic [SUB_BITS-1:0] SUB_BANG2  = 5'd21;
	localparam logic [SUB_BITS-1:0] SUB_SHR    = 5'd22;
	localparam logic [SUB_BITS-1:0] SUB_GE     = 5'd23;
	localparam logic [SUB_BITS-1:0] SUB_SHL    = 5'd24;
	localparam logic [SUB_BITS-1:0] SUB_LE     = 5'd25;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	localparam logic [23:0]          KW_DEF    = 24'h646566;
	localparam logic [23:0]          KW_FUN    = 24'h66756E;
	localparam logic [PREFIX_BITS-1:0] KW_RTN  = 48'h72657475726E;

	localparam int CFG_ADDR_BITS = 3;
	localparam logic [0:0] REG_FIRST_LINE = 1'b0;

	typedef enum logic [5:0] {
		M_FIND    = 6'b000001,
		M_SPACE   = 6'b000010,
		M_COMMENT = 6'b000100,
		M_IDENT   = 6'b001000,
		M_INT     = 6'b010000,
		M_SYMBOL  = 6'b100000
	} lex_mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LINE_BITS-1:0]   line;
		logic [COL_BITS-1:0]    column;
		logic [OFFSET_BITS-1:0] length;
		logic                   is_error;
		logic                   error_seen;
		logic                   last;
	} tok_word_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// substate of a single symbol, none when the byte is not a symbol
	function automatic logic [SUB_BITS-1:0] sym_index(input logic [7:0] c);
		logic [SUB_BITS-1:0] s;
		case (c)
			CH_LPAR:  s = 5'd1;
			CH_RPAR:  s = 5'd2;
			CH_LBRC:  s = 5'd3;
			CH_RBRC:  s = 5'd4;
			CH_SEMI:  s = 5'd5;
			CH_EQ:    s = SUB_EQ;
			CH_PLUS:  s = SUB_PLUS;
			CH_MINUS: s = SUB_MINUS;
			CH_STAR:  s = 5'd9;
			CH_SLASH: s = SUB_SLASH;
			CH_PCT:   s = 5'd11;
			CH_BANG:  s = SUB_BANG;
			CH_GT:    s = SUB_GT;
			CH_LT:    s = SUB_LT;
			CH_AMP:   s = 5'd15;
			CH_BAR:   s = 5'd16;
			CH_CARET: s = 5'd17;
			default:  s = SUB_NONE;
		endcase
		return s;
	endfunction

	// double symbol reached from a single one, none when the symbol ends
	function automatic logic [SUB_BITS-1:0] sym_next(input logic [SUB_BITS-1:0] sub,
		input logic [7:0] c);
		logic [SUB_BITS-1:0] s;
		s = SUB_NONE;
		case (sub)
			SUB_EQ:    if (c == CH_GT) s = SUB_ARROW;
			SUB_PLUS:  if (c == CH_PLUS) s = SUB_INC;
			SUB_MINUS: if (c == CH_MINUS) s = SUB_DEC;
			SUB_BANG:  if (c == CH_BANG) s = SUB_BANG2;
			SUB_GT: begin
				if (c == CH_GT) s = SUB_SHR;
				else if (c == CH_EQ) s = SUB_GE;
			end
			SUB_LT: begin
				if (c == CH_LT) s = SUB_SHL;
				else if (c == CH_EQ) s = SUB_LE;
			end
			default: s = SUB_NONE;
		endcase
		return s;
	endfunction

endpackage

[sv/tok_lexer.sv]
// lexer state and the one-pass decode of a byte into up to two token words
module tok_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           ch,
	input  logic                 cfg_we,
	input  logic                 cfg_first,
	output logic [1:0]           push_n,
	output tok_pkg::tok_word_t   word0,
	output tok_pkg::tok_word_t   word1
);

	localparam logic [tok_pkg::OFFSET_BITS-1:0] POS_MAX  = '1;
	localparam logic [tok_pkg::LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [tok_pkg::COL_BITS-1:0]    COL_MAX  = '1;

	tok_pkg::lex_mode_t mode_q, mode_d;
	logic [tok_pkg::SUB_BITS-1:0]    sub_q, sub_d;
	logic [tok_pkg::OFFSET_BITS-1:0] tstart_q, tstart_d, pos_q, pos_d, adv_pos;
	logic [tok_pkg::LINE_BITS-1:0]   tline_q, tline_d, line_q, line_d, adv_line;
	logic [tok_pkg::COL_BITS-1:0]    tcol_q, tcol_d, col_q, col_d, adv_col;
	logic [tok_pkg::PREFIX_BITS-1:0] prefix_q, prefix_d;
	logic error_q, error_d, done_q, done_d;

	logic adv, pend, find, found;
	logic [tok_pkg::KIND_BITS-1:0]   pend_kind, id_kind;
	logic [tok_pkg::OFFSET_BITS-1:0] cur_len;
	logic [tok_pkg::SUB_BITS-1:0]    sym_sub, nx_sub;
	tok_pkg::tok_word_t pw, fw;

	// position after this byte, saturating
	always_comb begin
		adv_pos  = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		adv_line = line_q;
		adv_col  = col_q;
		if (ch == tok_pkg::CH_LF) begin
			if (line_q != LINE_MAX) adv_line = line_q + 1'b1;
			adv_col = '0;
		end else if (col_q != COL_MAX) begin
			adv_col = col_q + 1'b1;
		end
	end

	assign cur_len = pos_q - tstart_q;
	assign sym_sub = tok_pkg::sym_index(ch);
	assign nx_sub  = tok_pkg::sym_next(sub_q, ch);

	always_comb begin
		id_kind = tok_pkg::KIND_IDENT;
		if (cur_len == tok_pkg::OFFSET_BITS'(3) && prefix_q[23:0] == tok_pkg::KW_DEF)
			id_kind = tok_pkg::KIND_DEF;
		else if (cur_len == tok_pkg::OFFSET_BITS'(3) && prefix_q[23:0] == tok_pkg::KW_FUN)
			id_kind = tok_pkg::KIND_FUN;
		else if (cur_len == tok_pkg::OFFSET_BITS'(6) && prefix_q == tok_pkg::KW_RTN)
			id_kind = tok_pkg::KIND_RETURN;
	end

	always_comb begin
		mode_d    = mode_q;
		sub_d     = sub_q;
		tstart_d  = tstart_q;
		tline_d   = tline_q;
		tcol_d    = tcol_q;
		prefix_d  = prefix_q;
		error_d   = error_q;
		done_d    = done_q;
		adv       = 1'b0;
		pend      = 1'b0;
		find      = 1'b0;
		found     = 1'b0;
		pend_kind = tok_pkg::KIND_END;
		fw        = '0;
		push_n    = 2'd0;
		word0     = '0;
		word1     = '0;

		if (step && !done_q) begin
			// continue the current token or close it
			unique case (mode_q)
				tok_pkg::M_FIND: find = 1'b1;
				tok_pkg::M_SPACE: begin
					if (tok_pkg::is_space(ch)) adv = 1'b1;
					else begin
						pend = 1'b1;
						pend_kind = tok_pkg::KIND_SPACE;
					end
				end
				tok_pkg::M_COMMENT: begin
					if (ch != tok_pkg::CH_LF && ch != tok_pkg::CH_NUL) adv = 1'b1;
					else begin
						pend = 1'b1;
						pend_kind = tok_pkg::KIND_COMMENT;
					end
				end
				tok_pkg::M_IDENT: begin
					if (tok_pkg::is_letter(ch)) begin
						adv = 1'b1;
						prefix_d = {prefix_q[tok_pkg::PREFIX_BITS-9:0], ch};
					end else begin
						pend = 1'b1;
						pend_kind = id_kind;
					end
				end
				tok_pkg::M_INT: begin
					if (tok_pkg::is_digit(ch)) adv = 1'b1;
					else begin
						pend = 1'b1;
						pend_kind = tok_pkg::KIND_INT;
					end
				end
				tok_pkg::M_SYMBOL: begin
					if (sub_q == tok_pkg::SUB_SLASH && ch == tok_pkg::CH_SLASH) begin
						adv = 1'b1;
						mode_d = tok_pkg::M_COMMENT;
						sub_d = tok_pkg::SUB_NONE;
					end else if (nx_sub != tok_pkg::SUB_NONE) begin
						adv = 1'b1;
						sub_d = nx_sub;
					end else begin
						pend = 1'b1;
						pend_kind = {1'b0, sub_q} + tok_pkg::KIND_SYM_BASE;
						sub_d = tok_pkg::SUB_NONE;
					end
				end
				default: find = 1'b1;
			endcase

			// the closing byte starts the next token
			if (pend || find) begin
				mode_d   = tok_pkg::M_FIND;
				tstart_d = pos_q;
				tline_d  = line_q;
				tcol_d   = col_q;
				if (ch == tok_pkg::CH_NUL) begin
					done_d = 1'b1;
					found  = 1'b1;
					fw.error_seen = error_q;
				end else if (tok_pkg::is_space(ch)) begin
					mode_d = tok_pkg::M_SPACE;
					adv = 1'b1;
				end else if (tok_pkg::is_digit(ch)) begin
					mode_d = tok_pkg::M_INT;
					adv = 1'b1;
				end else if (sym_sub != tok_pkg::SUB_NONE) begin
					mode_d = tok_pkg::M_SYMBOL;
					sub_d = sym_sub;
					adv = 1'b1;
				end else if (tok_pkg::is_letter(ch)) begin
					mode_d = tok_pkg::M_IDENT;
					prefix_d = {{(tok_pkg::PREFIX_BITS-8){1'b0}}, ch};
					adv = 1'b1;
				end else begin
					error_d = 1'b1;
					adv = 1'b1;
					found = 1'b1;
					fw.kind = tok_pkg::KIND_UNKNOWN;
					fw.start = pos_q;
					fw.line = line_q;
					fw.column = col_q;
					fw.length = adv_pos - pos_q;
					fw.is_error = 1'b1;
					fw.error_seen = 1'b1;
				end
			end

			pw = '0;
			pw.kind = pend_kind;
			pw.start = tstart_q;
			pw.line = tline_q;
			pw.column = tcol_q;
			pw.length = cur_len;
			pw.error_seen = error_q;

			if (pend && found) begin
				word0 = pw;
				word1 = fw;
				word1.last = 1'b1;
				push_n = 2'd2;
			end else if (pend) begin
				word0 = pw;
				word0.last = 1'b1;
				push_n = 2'd1;
			end else if (found) begin
				word0 = fw;
				word0.last = 1'b1;
				push_n = 2'd1;
			end
		end else begin
			pw = '0;
			if (step) begin
				// after end of text every byte gives one end word
				word0.error_seen = error_q;
				word0.last = 1'b1;
				push_n = 2'd1;
			end
		end
	end

	assign pos_d  = adv ? adv_pos : pos_q;
	assign line_d = adv ? adv_line : line_q;
	assign col_d  = adv ? adv_col : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tok_pkg::M_FIND;
			sub_q    <= tok_pkg::SUB_NONE;
			tstart_q <= '0;
			tline_q  <= {{(tok_pkg::LINE_BITS-1){1'b0}}, 1'b1};
			tcol_q   <= '0;
			pos_q    <= '0;
			line_q   <= {{(tok_pkg::LINE_BITS-1){1'b0}}, 1'b1};
			col_q    <= '0;
			prefix_q <= '0;
			error_q  <= 1'b0;
			done_q   <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_d;
			sub_q    <= sub_d;
			tstart_q <= tstart_d;
			tline_q  <= tline_d;
			tcol_q   <= tcol_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			col_q    <= col_d;
			prefix_q <= prefix_d;
			error_q  <= error_d;
			done_q   <= done_d;
		end else if (cfg_we && pos_q == '0) begin
			line_q  <= {{(tok_pkg::LINE_BITS-1){1'b0}}, cfg_first};
			tline_q <= {{(tok_pkg::LINE_BITS-1){1'b0}}, cfg_first};
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n) done_q |=> done_q)
		else $error("done flag dropped");
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n) error_q |=> error_q)
		else $error("error flag dropped");
	a_done_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_q) |-> (push_n == 2'd1 && word0.kind == tok_pkg::KIND_END))
		else $error("finished lexer must give one end word");
	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> pos_q >= $past(pos_q))
		else $error("position went back");

endmodule

[sv/tok_wordq.sv]
// result queue that takes up to two token words a cycle and gives one while out_stall is low
module tok_wordq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     push_n,
	input  tok_pkg::tok_word_t             word0,
	input  tok_pkg::tok_word_t             word1,
	input  logic                           out_stall,
	output logic                           out_valid,
	output tok_pkg::tok_word_t             head,
	output logic [tok_pkg::WQ_CNT_BITS-1:0] count
);

	tok_pkg::tok_word_t                mem_q [tok_pkg::WQ_DEPTH];
	logic [tok_pkg::WQ_PTR_BITS-1:0]   wr_q, rd_q, wr_nx;
	logic [tok_pkg::WQ_CNT_BITS-1:0]   cnt_q;
	logic pop;

	assign out_valid = cnt_q != '0;
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign count     = cnt_q;
	assign wr_nx     = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= word0;
		if (push_n == 2'd2) mem_q[wr_nx] <= word1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + tok_pkg::WQ_PTR_BITS'(push_n);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + tok_pkg::WQ_CNT_BITS'(push_n)
				- tok_pkg::WQ_CNT_BITS'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, cnt_q} + (tok_pkg::WQ_CNT_BITS+1)'(push_n)) <=
		(tok_pkg::WQ_CNT_BITS+1)'(tok_pkg::WQ_DEPTH)))
		else $error("word queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tok_pkg::WQ_CNT_BITS'(tok_pkg::WQ_DEPTH))
		else $error("word count out of range");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(head)))
		else $error("stalled word changed");

endmodule

[sv/source_tokenizer.sv]
// source tokenizer top level: input register, lexer, word queue and register port
// a word leaves via input register, lexer and queue after its closing byte is taken
// throughput: a byte and a word per cycle unless stalled; a byte can give two words
// input stalls while the eight-word queue could not hold the words still to come
// reset clears lexer state and queue; first line number returns to one
module source_tokenizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          text_byte,
	input  logic                                end_of_text,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tok_pkg::KIND_BITS-1:0]       token_kind,
	output logic [tok_pkg::OFFSET_BITS-1:0]     start_offset,
	output logic [tok_pkg::LINE_BITS-1:0]       start_line,
	output logic [tok_pkg::COL_BITS-1:0]        start_column,
	output logic [tok_pkg::OFFSET_BITS-1:0]     token_length,
	output logic                                is_error,
	output logic                                error_seen,
	output logic                                last_of_run,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tok_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic                                valid_s1;
	logic [7:0]                          ch_s1;
	logic                                first_line_q;
	logic                                cfg_we, accept;
	logic [1:0]                          push_n;
	logic [tok_pkg::WQ_CNT_BITS-1:0]     count;
	tok_pkg::tok_word_t                  word0, word1, head;

	// room for two words from the staged byte and two from a new one
	assign in_stall = ({1'b0, count} + {valid_s1, 1'b0}) >
		(tok_pkg::WQ_CNT_BITS+1)'(tok_pkg::WQ_DEPTH - 2);
	assign accept = in_valid && !in_stall;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
		&& paddr[tok_pkg::CFG_ADDR_BITS-1:2] == tok_pkg::REG_FIRST_LINE;
	assign prdata = (paddr[tok_pkg::CFG_ADDR_BITS-1:2] == tok_pkg::REG_FIRST_LINE)
		? {31'b0, first_line_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			first_line_q <= 1'b1;
		end else begin
			valid_s1 <= accept;
			if (cfg_we) first_line_q <= pwdata[0];
		end
	end

	// end of text acts as a zero byte
	always_ff @(posedge clk) begin
		if (accept) ch_s1 <= end_of_text ? tok_pkg::CH_NUL : text_byte;
	end

	tok_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1),
		.ch        (ch_s1),
		.cfg_we    (cfg_we),
		.cfg_first (pwdata[0]),
		.push_n    (push_n),
		.word0     (word0),
		.word1     (word1)
	);

	tok_wordq u_wordq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.word0     (word0),
		.word1     (word1),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.count     (count)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign start_line   = head.line;
	assign start_column = head.column;
	assign token_length = head.length;
	assign is_error     = head.is_error;
	assign error_seen   = head.error_seen;
	assign last_of_run  = head.last;

	a_staged: assert property (@(posedge clk) disable iff (!arst_n) accept |=> valid_s1)
		else $error("accepted byte not staged");
	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> push_n == 2'd0)
		else $error("words pushed without a staged byte");
	a_stall_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> count != '0)
		else $error("input stalled with an empty queue");

endmodule

[verif/tb_top.sv]
// self-checking testbench for source_tokenizer: random text in, tokens checked against a predictor
`timescale 1ns / 1ps

module tb_top;
	import tok_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef enum int {PACE_FULL, PACE_SRC, PACE_SINK, PACE_BOTH} pace_t;

	localparam logic [CFG_ADDR_BITS-1:0] FIRST_LINE_ADDR = CFG_ADDR_BITS'(4 * REG_FIRST_LINE);
	localparam string SYM_CHARS = "(){};=+-*/%!><&|^";
	localparam string PAIR_CHARS = "=>++--!!>>>=<<<=//";
	localparam string ODD_CHARS = "#$@`~\"'.,:?[]\\";
	localparam string BLANK_CHARS = " \t\r\n";

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [7:0]               text_byte = 8'h00;
	logic                     end_of_text = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [KIND_BITS-1:0]     token_kind;
	logic [OFFSET_BITS-1:0]   start_offset;
	logic [LINE_BITS-1:0]     start_line;
	logic [COL_BITS-1:0]      start_column;
	logic [OFFSET_BITS-1:0]   token_length;
	logic                     is_error;
	logic                     error_seen;
	logic                     last_of_run;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	source_tokenizer dut (.*);

	always #4 clk = ~clk;

	text_item_t text_q[$];
	tok_word_t  expected_tokens[$];
	int         queued = 0;
	int         mismatches = 0;
	pace_t      pace = PACE_FULL;

	// predictor state
	logic                   lx_first_line;
	lex_mode_t              lx_mode;
	logic [SUB_BITS-1:0]    lx_sub;
	logic [OFFSET_BITS-1:0] lx_tok_start, lx_pos;
	logic [LINE_BITS-1:0]   lx_tok_line, lx_line;
	logic [COL_BITS-1:0]    lx_tok_col, lx_col;
	logic [PREFIX_BITS-1:0] lx_prefix;
	logic                   lx_err, lx_done;

	function automatic void lex_reset();
		lx_first_line = 1'b1;
		lx_mode = M_FIND;
		lx_sub = SUB_NONE;
		lx_tok_start = '0;
		lx_pos = '0;
		lx_tok_line = LINE_BITS'(lx_first_line);
		lx_line = LINE_BITS'(lx_first_line);
		lx_tok_col = '0;
		lx_col = '0;
		lx_prefix = '0;
		lx_err = 1'b0;
		lx_done = 1'b0;
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [SUB_BITS-1:0] single_sub(input logic [7:0] c);
		for (int i = 0; i < SYM_CHARS.len(); i++)
			if (c == SYM_CHARS[i])
				return SUB_BITS'(i + 1);
		return SUB_NONE;
	endfunction

	function automatic logic [SUB_BITS-1:0] pair_sub(input logic [SUB_BITS-1:0] s,
		input logic [7:0] c);
		case (s)
			SUB_EQ:    return c == CH_GT ? SUB_ARROW : SUB_NONE;
			SUB_PLUS:  return c == CH_PLUS ? SUB_INC : SUB_NONE;
			SUB_MINUS: return c == CH_MINUS ? SUB_DEC : SUB_NONE;
			SUB_BANG:  return c == CH_BANG ? SUB_BANG2 : SUB_NONE;
			SUB_GT:    return c == CH_GT ? SUB_SHR : (c == CH_EQ ? SUB_GE : SUB_NONE);
			SUB_LT:    return c == CH_LT ? SUB_SHL : (c == CH_EQ ? SUB_LE : SUB_NONE);
			default:   return SUB_NONE;
		endcase
	endfunction

	function automatic void step_pos(input logic [7:0] c);
		if (c == CH_LF) begin
			if (lx_line != '1)
				lx_line++;
			lx_col = '0;
		end else if (lx_col != '1) begin
			lx_col++;
		end
		if (lx_pos != '1)
			lx_pos++;
	endfunction

	function automatic void push_token(input logic [KIND_BITS-1:0] kind, input logic located,
		input logic err);
		tok_word_t w;
		w = '0;
		w.kind = kind;
		if (located) begin
			w.start = lx_tok_start;
			w.line = lx_tok_line;
			w.column = lx_tok_col;
			w.length = lx_pos - lx_tok_start;
		end
		w.is_error = err;
		w.error_seen = lx_err;
		expected_tokens.insert(expected_tokens.size(), w);
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind();
		logic [OFFSET_BITS-1:0] len;
		len = lx_pos - lx_tok_start;
		if (len == 3 && lx_prefix[23:0] == KW_DEF)
			return KIND_DEF;
		if (len == 3 && lx_prefix[23:0] == KW_FUN)
			return KIND_FUN;
		if (len == 6 && lx_prefix == KW_RTN)
			return KIND_RETURN;
		return KIND_IDENT;
	endfunction

	// expected tokens for one accepted byte
	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		logic [7:0]          c;
		logic                again;
		int                  n;
		logic [SUB_BITS-1:0] nx;
		tok_word_t           w;
		c = eot ? CH_NUL : b;
		n = 0;
		again = 1'b1;
		if (lx_done) begin
			push_token(KIND_END, 1'b0, 1'b0);
			n = 1;
			again = 1'b0;
		end
		while (again) begin
			again = 1'b0;
			case (lx_mode)
				M_SPACE: begin
					if (blank(c)) begin
						step_pos(c);
					end else begin
						push_token(KIND_SPACE, 1'b1, 1'b0);
						n++;
						lx_mode = M_FIND;
						again = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == CH_LF || c == CH_NUL) begin
						push_token(KIND_COMMENT, 1'b1, 1'b0);
						n++;
						lx_mode = M_FIND;
						again = 1'b1;
					end else begin
						step_pos(c);
					end
				end
				M_IDENT: begin
					if (letter(c)) begin
						lx_prefix = {lx_prefix[PREFIX_BITS-9:0], c};
						step_pos(c);
					end else begin
						push_token(word_kind(), 1'b1, 1'b0);
						n++;
						lx_mode = M_FIND;
						again = 1'b1;
					end
				end
				M_INT: begin
					if (digit(c)) begin
						step_pos(c);
					end else begin
						push_token(KIND_INT, 1'b1, 1'b0);
						n++;
						lx_mode = M_FIND;
						again = 1'b1;
					end
				end
				M_SYMBOL: begin
					nx = pair_sub(lx_sub, c);
					if (lx_sub == SUB_SLASH && c == CH_SLASH) begin
						lx_mode = M_COMMENT;
						lx_sub = SUB_NONE;
						step_pos(c);
					end else if (nx != SUB_NONE) begin
						lx_sub = nx;
						step_pos(c);
					end else begin
						push_token(KIND_SYM_BASE + KIND_BITS'(lx_sub), 1'b1, 1'b0);
						n++;
						lx_sub = SUB_NONE;
						lx_mode = M_FIND;
						again = 1'b1;
					end
				end
				default: begin
					lx_mode = M_FIND;
					lx_tok_start = lx_pos;
					lx_tok_line = lx_line;
					lx_tok_col = lx_col;
					if (c == CH_NUL) begin
						lx_done = 1'b1;
						push_token(KIND_END, 1'b0, 1'b0);
						n++;
					end else if (blank(c)) begin
						lx_mode = M_SPACE;
						step_pos(c);
					end else if (digit(c)) begin
						lx_mode = M_INT;
						step_pos(c);
					end else if (single_sub(c) != SUB_NONE) begin
						lx_mode = M_SYMBOL;
						lx_sub = single_sub(c);
						step_pos(c);
					end else if (letter(c)) begin
						lx_mode = M_IDENT;
						lx_prefix = PREFIX_BITS'(c);
						step_pos(c);
					end else begin
						lx_err = 1'b1;
						step_pos(c);
						push_token(KIND_UNKNOWN, 1'b1, 1'b1);
						n++;
					end
				end
			endcase
		end
		if (n > 0) begin
			w = expected_tokens.pop_back();
			w.last = 1'b1;
			expected_tokens.insert(expected_tokens.size(), w);
		end
	endfunction

	// text generation
	function automatic void add_byte(input logic [7:0] c, input logic eot = 1'b0);
		text_item_t t;
		t.ch = c;
		t.eot = eot;
		text_q.insert(text_q.size(), t);
		queued++;
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] any_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		return "_";
	endfunction

	function automatic void add_token();
		int         k;
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1: begin
				k = $urandom_range(1, 8);
				repeat (k) add_byte(any_letter());
			end
			2: begin
				case ($urandom_range(0, 6))
					0: add_str("def");
					1: add_str("fun");
					2: add_str("return");
					3: add_str("de");
					4: add_str("retur");
					5: add_str("funny");
					default: add_str("Def");
				endcase
			end
			3: begin
				k = $urandom_range(1, 5);
				repeat (k) add_byte(8'("0" + $urandom_range(0, 9)));
			end
			4: add_byte(SYM_CHARS[$urandom_range(0, SYM_CHARS.len() - 1)]);
			5: begin
				k = 2 * $urandom_range(0, PAIR_CHARS.len() / 2 - 1);
				add_byte(PAIR_CHARS[k]);
				add_byte(PAIR_CHARS[k + 1]);
			end
			6: begin
				add_str("//");
				k = $urandom_range(0, 10);
				repeat (k) begin
					c = 8'($urandom_range(1, 255));
					add_byte(c == CH_LF ? "x" : c);
				end
				add_byte(CH_LF);
			end
			7: begin
				k = $urandom_range(1, 4);
				repeat (k) add_byte(BLANK_CHARS[$urandom_range(0, 3)]);
			end
			8: begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range(128, 255)));
				else
					add_byte(ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)]);
			end
			default: add_byte(8'($urandom_range(1, 255)));
		endcase
		if ($urandom_range(0, 1))
			add_byte(" ");
	endfunction

	// driver: one byte per handshake, predicted when accepted
	always @(posedge clk) begin
		text_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				lex_byte(text_byte, end_of_text);
			if (!in_valid || !in_stall) begin
				if (text_q.size() != 0 &&
					!((pace == PACE_SRC && $urandom_range(0, 99) < 46) ||
					(pace == PACE_BOTH && $urandom_range(0, 99) < 27))) begin
					nxt = text_q.pop_front();
					text_byte <= nxt.ch;
					end_of_text <= nxt.eot;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_token(input tok_word_t w);
		if (token_kind !== w.kind) begin
			$error("token_kind: expected %0d, got %0d", w.kind, token_kind);
			mismatches++;
		end
		if (start_offset !== w.start) begin
			$error("start_offset: expected %0d, got %0d", w.start, start_offset);
			mismatches++;
		end
		if (start_line !== w.line) begin
			$error("start_line: expected %0d, got %0d", w.line, start_line);
			mismatches++;
		end
		if (start_column !== w.column) begin
			$error("start_column: expected %0d, got %0d", w.column, start_column);
			mismatches++;
		end
		if (token_length !== w.length) begin
			$error("token_length: expected %0d, got %0d", w.length, token_length);
			mismatches++;
		end
		if (is_error !== w.is_error) begin
			$error("is_error: expected %0d, got %0d", w.is_error, is_error);
			mismatches++;
		end
		if (error_seen !== w.error_seen) begin
			$error("error_seen: expected %0d, got %0d", w.error_seen, error_seen);
			mismatches++;
		end
		if (last_of_run !== w.last) begin
			$error("last_of_run: expected %0d, got %0d", w.last, last_of_run);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$error("token_kind: expected none, got %0d", token_kind);
					mismatches++;
				end else begin
					check_token(expected_tokens.pop_front());
				end
			end
			out_stall <= (pace == PACE_SINK && $urandom_range(0, 99) < 46) ||
				(pace == PACE_BOTH && $urandom_range(0, 99) < 27);
		end
	end

	task automatic reg_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= FIRST_LINE_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr) begin
			lx_first_line = wdata[0];
			if (lx_pos == '0) begin
				lx_line = LINE_BITS'(lx_first_line);
				lx_tok_line = LINE_BITS'(lx_first_line);
			end
		end
	endtask

	task automatic set_first_line(input logic v);
		logic [31:0] rd;
		reg_access(1'b1, {31'b0, v}, rd);
		reg_access(1'b0, '0, rd);
		if (rd !== {31'b0, v}) begin
			$error("first_line_number: expected %0d, got %0d", v, rd);
			mismatches++;
		end
	endtask

	task automatic drain(input int tail);
		while (text_q.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		int stop;
		lex_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_first_line(1'b1);
		set_first_line(1'b0);

		// keywords, blanks, integer, comment, unknown bytes
		add_str("def\tfun return 9 //x\n#");
		add_byte(8'hFF);
		for (int p = PACE_FULL; p <= PACE_BOTH; p++) begin
			pace = pace_t'(p);
			stop = queued + 250;
			while (queued < stop)
				add_token();
			drain(8);
			if (pace != PACE_BOTH)
				set_first_line(p[0]);
		end

		// pending identifier then end of text, then bytes after the end
		add_str("ab");
		add_byte(8'($urandom_range(0, 255)), 1'b1);
		add_byte(CH_NUL);
		add_byte(8'($urandom_range(1, 255)));
		add_byte(8'($urandom_range(0, 255)), 1'b1);
		drain(10);
		if (mismatches == 0)
			$display("source_tokenizer regression: pass");
		else
			$display("source_tokenizer regression: fail");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("source_tokenizer regression: fail");
		$finish;
	end

endmodule

[source_tokenizer.f]
sv/tok_pkg.sv
sv/tok_lexer.sv
sv/tok_wordq.sv
sv/source_tokenizer.sv
verif/tb_top.sv
